// ===== src/sgf_pkg.sv =====
// Shared types, constants and helpers for the Savitzky-Golay edge-replicating FIR.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sgf_pkg;

  // Parameter defaults for the top level
  localparam int MAX_TAPS_DEF       = 15;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 12;

  // Fixed formats of the register map
  localparam int COEF_BITS     = 16;
  localparam int TAPS_PER_REG  = 4;
  localparam int NUM_COEF_REGS = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int WIN_BITS      = 4;
  localparam int COUNT_BITS    = 4;
  localparam int HALF_BITS     = 3;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = 4'd15;

  // Result queue depth; must exceed the pipeline latency
  localparam int FIFO_DEPTH = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW      = 3'd0,
    REG_COEF_0_3    = 3'd1,
    REG_COEF_4_7    = 3'd2,
    REG_COEF_8_11   = 3'd3,
    REG_COEF_12_15  = 3'd4
  } cfg_reg_t;

  // Control that travels beside each word down the cell chain
  typedef struct packed {
    logic valid;
    logic last;
  } sgf_ctrl_t;

  // Taps in use: clamp to the tap count, then drop an even value to the next lower odd one (zero becomes one)
  function automatic logic [WIN_BITS-1:0] taps_in_use(input logic [WIN_BITS-1:0] wl,
                                                      input int max_taps);
    logic [WIN_BITS-1:0] w;
    w = wl;
    if (int'(w) > max_taps) begin
      w = WIN_BITS'(max_taps);
    end
    if (!w[0]) begin
      w = (w == '0) ? WIN_BITS'(1) : w - WIN_BITS'(1);
    end
    return w;
  endfunction

endpackage

// ===== src/sgf_cell.sv =====
// One multiply-accumulate cell of the filter chain.
// Depends on sgf_pkg; instantiated MAX_TAPS times by the top level.
`timescale 1ns / 1ps

module sgf_cell #(
  parameter int IDX         = 0,
  parameter int MAX_TAPS    = 15,
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 40
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [sgf_pkg::COEF_BITS-1:0] tap,
  input  sgf_pkg::sgf_ctrl_t                   in_ctrl,
  input  logic signed [ACC_BITS-1:0]           in_acc,
  input  logic signed [SAMPLE_BITS-1:0]        in_win [MAX_TAPS],
  output sgf_pkg::sgf_ctrl_t                   out_ctrl,
  output logic signed [ACC_BITS-1:0]           out_acc,
  output logic signed [SAMPLE_BITS-1:0]        out_win [MAX_TAPS]
);
  import sgf_pkg::*;

  logic signed [SAMPLE_BITS+COEF_BITS-1:0] product;

  assign product = tap * in_win[IDX];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else begin
      out_ctrl <= in_ctrl;
    end
  end

  // Payload: add this cell's term and hand the window on
  always_ff @(posedge clk) begin
    out_acc <= in_acc + ACC_BITS'(product);
    out_win <= in_win;
  end

endmodule

// ===== src/sgf_fifo.sv =====
// Result queue: first-word-fall-through FIFO in flip-flops.
// Depends on sgf_pkg only for the shared import convention.
`timescale 1ns / 1ps

module sgf_fifo #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] dout
);
  import sgf_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== src/savitzky_golay_fir_edge_replicate_top.sv =====
// Top level of the Savitzky-Golay smoothing FIR with edge replication.
// Depends on sgf_pkg, sgf_cell and sgf_fifo.
`timescale 1ns / 1ps

// Usage:
//   s_tvalid/s_tready/s_tdata/s_tlast carry one signed sample per word; s_tlast
//   marks the last sample of a block. m_* carries one filtered sample per word;
//   m_tlast marks the last filtered sample of a block.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the window length (index 0)
//   and the four packed Q4.12 tap registers (indexes 1..4); cfg_ready is always
//   high. Write only while no block is in flight.
//   The first sample of a block fills the whole delay line. Output i leaves
//   once sample i+half is in; the last sample triggers half flush steps that
//   repeat it, one per cycle while the result queue has room; s_tready stays low.
//   Throughput: one sample per cycle while the result queue has room; flush steps
//   at a block end take no input. Each result passes the snapshot register, the chain
//   of MAX_TAPS multiply-accumulate cells, the rounding register and the queue.
//   A receiver stall fills the FIFO_DEPTH result queue; input is taken as long
//   as results in flight plus queued stay below that depth, so a stalled output
//   does not stop the input until the queue is committed.
//   Reset clears the window length to 1, all taps to zero and the block state.
module savitzky_golay_fir_edge_replicate_top #(
  parameter int MAX_TAPS       = sgf_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS    = sgf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = sgf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Input stream
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,   // sample_in
  input  logic                                     s_tlast,   // block_end
  // Output stream
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,   // filtered
  output logic                                     m_tlast,   // last_out
  // Configuration writes
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [sgf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [sgf_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import sgf_pkg::*;

  localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ACC_BITS  = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS + 1) + 1;
  localparam int OCC_BITS  = $clog2(FIFO_DEPTH + 1);
  localparam logic signed [ACC_BITS-1:0] ROUND_ADD = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_HI = (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [ACC_BITS-1:0] SAT_LO = -(ACC_BITS'(1) <<< (SAMPLE_BITS - 1));

  // ---------------- Configuration registers ----------------
  logic [WIN_BITS-1:0]      window_length;
  logic [CFG_DATA_BITS-1:0] coef_reg [NUM_COEF_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WIN_BITS'(1);
      for (int r = 0; r < NUM_COEF_REGS; r++) begin
        coef_reg[r] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW:     window_length <= cfg_data[WIN_BITS-1:0];
        REG_COEF_0_3:   coef_reg[0]   <= cfg_data;
        REG_COEF_4_7:   coef_reg[1]   <= cfg_data;
        REG_COEF_8_11:  coef_reg[2]   <= cfg_data;
        REG_COEF_12_15: coef_reg[3]   <= cfg_data;
        default: ;  // drop writes beyond the register map
      endcase
    end
  end

  logic [WIN_BITS-1:0]  w;
  logic [HALF_BITS-1:0] half;

  assign w    = taps_in_use(window_length, MAX_TAPS);
  assign half = w[WIN_BITS-1:1];

  // ---------------- Front end: delay line and block control ----------------
  logic signed [SAMPLE_BITS-1:0] dl      [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] dl_next [MAX_TAPS];
  logic                          started;
  logic [COUNT_BITS-1:0]         cnt;
  logic                          flushing;
  logic [HALF_BITS-1:0]          flush_step;
  logic [COUNT_BITS-1:0]         n_hold;
  logic signed [SAMPLE_BITS-1:0] s_hold;
  logic [OCC_BITS-1:0]           occ;

  logic                          step_ok;
  logic                          in_fire;
  logic                          flush_fire;
  logic [COUNT_BITS-1:0]         n_cur;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          issue;
  logic                          issue_last;
  logic                          pop;

  assign sample_in  = signed'(s_tdata[SAMPLE_BITS-1:0]);
  assign step_ok    = (occ < OCC_BITS'(FIFO_DEPTH));
  assign s_tready   = !flushing && step_ok;
  assign in_fire    = s_tvalid && s_tready;
  assign flush_fire = flushing && step_ok;
  assign n_cur      = started ? cnt : '0;

  always_comb begin
    issue      = 1'b0;
    issue_last = 1'b0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      dl_next[k] = dl[k];
    end
    if (in_fire) begin
      // First sample of a block fills the line; later ones shift in
      for (int k = 0; k < MAX_TAPS; k++) begin
        dl_next[k] = (!started || k == 0) ? sample_in : dl[(k > 0) ? k - 1 : 0];
      end
      issue      = (n_cur >= COUNT_BITS'(half));
      issue_last = s_tlast && (half == '0);
    end else if (flush_fire) begin
      // Flush step: repeat the last sample of the block
      for (int k = 0; k < MAX_TAPS; k++) begin
        dl_next[k] = (k == 0) ? s_hold : dl[(k > 0) ? k - 1 : 0];
      end
      issue      = ((COUNT_BITS + 1)'(n_hold) + (COUNT_BITS + 1)'(flush_step))
                   >= (COUNT_BITS + 1)'(half);
      issue_last = (flush_step == half);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      cnt        <= '0;
      flushing   <= 1'b0;
      flush_step <= '0;
    end else if (in_fire) begin
      if (s_tlast) begin
        started    <= 1'b0;
        cnt        <= '0;
        flushing   <= (half != '0);
        flush_step <= HALF_BITS'(1);
      end else begin
        started <= 1'b1;
        cnt     <= (n_cur < COUNT_LIMIT) ? n_cur + COUNT_BITS'(1) : COUNT_LIMIT;
      end
    end else if (flush_fire) begin
      if (flush_step == half) begin
        flushing <= 1'b0;
      end else begin
        flush_step <= flush_step + HALF_BITS'(1);
      end
    end
  end

  // Payload of the front end: line contents and the values a flush needs
  always_ff @(posedge clk) begin
    dl <= dl_next;
    if (in_fire) begin
      n_hold <= n_cur;
      s_hold <= sample_in;
    end
  end

  // Results in flight or queued; bounds the queue so it never overflows
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_BITS'(issue) - OCC_BITS'(pop);
    end
  end

  // ---------------- Snapshot: align the window so cell t sees its sample ----------------
  sgf_ctrl_t                     ctrl_chain [MAX_TAPS+1];
  logic signed [ACC_BITS-1:0]    acc_chain  [MAX_TAPS+1];
  logic signed [SAMPLE_BITS-1:0] win_chain  [MAX_TAPS+1][MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] win_aligned [MAX_TAPS];

  always_comb begin
    for (int t = 0; t < MAX_TAPS; t++) begin
      win_aligned[t] = '0;
      for (int k = 0; k < MAX_TAPS; k++) begin
        if (t < int'(w) && k == int'(w) - 1 - t) begin
          win_aligned[t] = dl_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_chain[0] <= '0;
    end else begin
      ctrl_chain[0].valid <= issue;
      ctrl_chain[0].last  <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    win_chain[0] <= win_aligned;
  end

  assign acc_chain[0] = '0;

  // ---------------- Chain of multiply-accumulate cells ----------------
  for (genvar t = 0; t < MAX_TAPS; t++) begin : g_cell
    logic signed [COEF_BITS-1:0] tap_eff;

    // Taps beyond the window contribute nothing
    assign tap_eff = (t < int'(w))
                   ? signed'(coef_reg[t / TAPS_PER_REG][COEF_BITS*(t % TAPS_PER_REG) +: COEF_BITS])
                   : '0;

    sgf_cell #(
      .IDX         (t),
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tap      (tap_eff),
      .in_ctrl  (ctrl_chain[t]),
      .in_acc   (acc_chain[t]),
      .in_win   (win_chain[t]),
      .out_ctrl (ctrl_chain[t+1]),
      .out_acc  (acc_chain[t+1]),
      .out_win  (win_chain[t+1])
    );
  end

  // ---------------- Round half up, shift and saturate ----------------
  logic signed [ACC_BITS-1:0]    rounded;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  sgf_ctrl_t                     res_ctrl;
  logic [SAMPLE_BITS-1:0]        res_data;

  assign rounded = (acc_chain[MAX_TAPS] + ROUND_ADD) >>> COEF_FRAC_BITS;

  always_comb begin
    if (rounded > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rounded < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = rounded[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctrl <= '0;
    end else begin
      res_ctrl <= ctrl_chain[MAX_TAPS];
    end
  end

  always_ff @(posedge clk) begin
    res_data <= sat_val;
  end

  // ---------------- Result queue and output ----------------
  logic [SAMPLE_BITS:0] fifo_out;

  assign pop = m_tvalid && m_tready;

  sgf_fifo #(
    .WIDTH (SAMPLE_BITS + 1),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_ctrl.valid),
    .din       ({res_ctrl.last, res_data}),
    .pop       (pop),
    .not_empty (m_tvalid),
    .dout      (fifo_out)
  );

  assign m_tdata = DATA_BITS'(fifo_out[SAMPLE_BITS-1:0]);
  assign m_tlast = fifo_out[SAMPLE_BITS];

endmodule

// ===== dv/tb_savitzky_golay_fir_edge_replicate_top.sv =====
// Self-checking testbench for the Savitzky-Golay edge-replicating FIR top level.
// Depends on sgf_pkg and savitzky_golay_fir_edge_replicate_top; predicts every
// filtered word in a small scoreboard class and checks it in stream order.
`timescale 1ns / 1ps

module tb_savitzky_golay_fir_edge_replicate_top;
  import sgf_pkg::*;

  localparam int TAPS       = MAX_TAPS_DEF;
  localparam int FRAC       = COEF_FRAC_BITS_DEF;
  localparam int RAND_WORDS = 410;
  localparam int HOLD_CYCLES = 300;
  // Leave generous slack after the last word for the pipeline to empty
  localparam int SETTLE     = 2 * TAPS + 8;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } smoothed_t;

  // Scoreboard: tracks the delay line, block position and registers, and
  // holds the filtered words still owed by the block.
  class sg_filter_checker;
    logic [WIN_BITS-1:0] win_len;
    logic [63:0]         coef_word [NUM_COEF_REGS];
    logic signed [15:0]  hist [TAPS];
    int                  seen;
    bit                  started;
    smoothed_t           owed_q [$];
    int                  errors;

    function new();
      win_len = WIN_BITS'(1);
      foreach (coef_word[i]) coef_word[i] = '0;
      foreach (hist[i]) hist[i] = '0;
      seen    = 0;
      started = 1'b0;
      errors  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] val);
      case (idx)
        REG_WINDOW:     win_len = val[WIN_BITS-1:0];
        REG_COEF_0_3:   coef_word[0] = val;
        REG_COEF_4_7:   coef_word[1] = val;
        REG_COEF_8_11:  coef_word[2] = val;
        REG_COEF_12_15: coef_word[3] = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function int active_taps();
      int w;
      w = int'(win_len);
      if (w > TAPS) w = TAPS;
      if (w % 2 == 0) w = (w == 0) ? 1 : w - 1;
      return w;
    endfunction

    function void push_sample(logic signed [15:0] smp);
      for (int k = TAPS - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = smp;
    endfunction

    // Dot product over the active taps, round half up, floor shift, saturate
    function logic signed [15:0] filter_point(int w);
      longint             acc;
      longint             q;
      logic signed [15:0] tap;
      acc = 0;
      for (int t = 0; t < w; t++) begin
        tap = coef_word[t / TAPS_PER_REG][COEF_BITS * (t % TAPS_PER_REG) +: COEF_BITS];
        acc += longint'(tap) * longint'(hist[w - 1 - t]);
      end
      acc += longint'(1) << (FRAC - 1);
      q = acc >>> FRAC;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_sample(logic signed [15:0] smp, logic lst);
      int w;
      int half;
      int n;
      w    = active_taps();
      half = w / 2;
      n    = started ? seen : 0;
      // The first sample of a block replicates itself over the whole line
      if (!started) foreach (hist[k]) hist[k] = smp;
      else push_sample(smp);
      if (n >= half) owed_q.push_back('{filter_point(w), lst && half == 0});
      if (lst) begin
        // Flush the tail by repeating the last sample
        for (int j = 1; j <= half; j++) begin
          push_sample(smp);
          if (n + j >= half) owed_q.push_back('{filter_point(w), j == half});
        end
        started = 1'b0;
        seen    = 0;
      end else begin
        started = 1'b1;
        seen    = (n < int'(COUNT_LIMIT)) ? n + 1 : int'(COUNT_LIMIT);
      end
    endfunction

    function void check_filtered(logic [15:0] got, logic got_last);
      smoothed_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: got %0d last %0b", $signed(got), got_last);
        return;
      end
      want = owed_q.pop_front();
      if (want.value !== got || want.last !== got_last) begin
        errors++;
        if (errors <= 10)
          $display("filtered mismatch: expected %0d last %0b, got %0d last %0b",
                   want.value, want.last, $signed(got), got_last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // sample_in
  logic        s_tlast;   // block_end
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // filtered
  logic        m_tlast;   // last_out
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [63:0] cfg_data;

  // Handshakes seen at the coming rising edge, sampled at the falling edge before it
  bit s_fire;
  bit m_fire;
  bit cfg_fire;

  // Idle control shared by the driving processes
  bit tx_steady;
  bit rx_steady;
  bit hold_req;

  sg_filter_checker sb = new();

  savitzky_golay_fir_edge_replicate_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Inputs change only at rising edges, so the values at the falling edge are
  // exactly what the next rising edge will see. Capture handshakes here and
  // feed the scoreboard: register writes first, then results, then samples.
  always @(negedge clk) begin
    cfg_fire = !rst && cfg_valid && cfg_ready;
    s_fire   = !rst && s_tvalid && s_tready;
    m_fire   = !rst && m_tvalid && m_tready;
    if (cfg_fire) sb.set_reg(cfg_index, cfg_data);
    if (m_fire) sb.check_filtered(m_tdata, m_tlast);
    if (s_fire) sb.note_sample(s_tdata, s_tlast);
  end

  // Receiver: stall about a quarter of the cycles, never while steady; on
  // request, hold off for a long stretch so the result queue fills and the
  // block pushes back on its input.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= rx_steady || ($urandom_range(99) >= 25);
      end
    end
  end

  // Offer one word; idle first at random unless the sender is steady.
  // Leave tvalid high on return so back-to-back words need no toggle.
  task automatic send_word(input logic [15:0] smp, input logic lst);
    while (!tx_steady && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_fire) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom_range(511) - 32'd256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Four taps of one register: full range, small realistic values, or flat
  function automatic logic [63:0] pick_taps(input int mode);
    logic [63:0] r;
    for (int i = 0; i < TAPS_PER_REG; i++) begin
      case (mode)
        0:       r[16*i +: 16] = 16'($urandom);
        1:       r[16*i +: 16] = 16'($urandom_range(1023) - 32'd512);
        default: r[16*i +: 16] = 16'h0200;
      endcase
    end
    return r;
  endfunction

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) send_word(pick_sample(), i == len - 1);
  endtask

  // Drop tvalid and wait until every owed word has come, then let the
  // pipeline settle so nothing is in flight.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_fire) @(posedge clk);
  endtask

  // Upper bits of the window write are junk on purpose; only four bits count
  task automatic load_config(input logic [3:0] win, input logic [63:0] c0,
                             input logic [63:0] c1, input logic [63:0] c2,
                             input logic [63:0] c3);
    write_reg(REG_WINDOW, {32'($urandom), 28'($urandom), win});
    write_reg(REG_COEF_0_3, c0);
    write_reg(REG_COEF_4_7, c1);
    write_reg(REG_COEF_8_11, c2);
    write_reg(REG_COEF_12_15, c3);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int rand_words;
    int phase;
    int budget;
    int sent;
    int len;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WINDOW;
    cfg_data  <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: single tap of zero, so every word filters to zero
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    drain();

    // Half tap on one sample: check round half up on both signs
    load_config(4'd1, 64'h0000_0000_0000_0800, '0, '0, '0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFD, 1'b0);
    send_word(16'h0003, 1'b1);
    drain();

    // Window of zero falls back to one tap; largest tap saturates both ways
    load_config(4'd0, 64'h0000_0000_0000_7FFF, '0, '0, '0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    drain();

    // Widest window with flat taps: a one-sample block, a block shorter
    // than half the window, and a block long enough to stream
    load_config(4'd15, {4{16'h0111}}, {4{16'h0111}}, {4{16'h0111}}, {4{16'h0111}});
    send_word(16'h4000, 1'b1);
    send_block(3);
    for (int i = 0; i < 9; i++) send_word(i[0] ? 16'h8000 : 16'h7FFF, i == 8);
    drain();

    // Even window drops to thirteen; alternating extreme taps overflow
    load_config(4'd14, {4{16'h8000}} ^ 64'h7FFF_0000_7FFF_0000 ^ 64'h8000_0000_8000_0000,
                {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    drain();

    // Random phases: new registers per phase, random block lengths. Phase 1
    // runs with no idling at all; phase 2 keeps the sender busy while the
    // receiver holds off, so the block stalls its input.
    rand_words = 0;
    phase      = 0;
    while (rand_words < RAND_WORDS) begin
      budget    = (phase == 2) ? 90 : 45;
      tx_steady = (phase == 1 || phase == 2);
      rx_steady = (phase == 1);
      load_config((phase == 1) ? 4'd15 : 4'($urandom_range(15)),
                  pick_taps($urandom_range(2)), pick_taps($urandom_range(2)),
                  pick_taps($urandom_range(2)), pick_taps($urandom_range(2)));
      if (phase == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < budget) begin
        len = ($urandom_range(5) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        send_block(len);
        sent += len;
        // Pause the sender until every owed word is out, now and then
        if ((phase == 0 && sent == len) || (phase > 2 && $urandom_range(3) == 0)) drain();
      end
      drain();
      rand_words += sent;
      phase++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule
